// File: hdl/sfct_pkg.sv
// Package for the sketch fragment coverage tracker.
// Holds the shared constants and the per-switch record type.
// It has no dependencies. The top level imports it.
package sfct_pkg;

    // Default sizes of the tracked tables.
    localparam int unsigned SWITCH_SLOTS_DEF   = 4;
    localparam int unsigned FRAGMENT_SLOTS_DEF = 65536;

    // Each bitmap memory word covers this many fragment ids.
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BIT_W  = 4;

    // Field widths.
    localparam int unsigned SKETCH_W = 16;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned DIST_W   = 17;
    localparam int unsigned LEVEL_W  = 7;
    localparam int unsigned PROD_W   = 25;

    // Constants used by the progress check and by reset.
    localparam logic [PROD_W-1:0]   PCT_SCALE    = PROD_W'(100);
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX    = 7'd127;
    localparam logic [LEVEL_W-1:0]  STEP_RESET   = 7'd1;
    localparam logic [SKETCH_W-1:0] SKETCH_RESET = 16'd1;

    // Per-switch record held in the switch state memory.
    typedef struct packed {
        logic [SKETCH_W-1:0] sketch;
        logic [TOTAL_W-1:0]  total;
        logic [DIST_W-1:0]   distinct;
        logic [LEVEL_W-1:0]  level;
    } t_sw_rec;

endpackage

// File: hdl/sketch_fragment_coverage_tracker.sv
// Top level of the sketch fragment coverage tracker.
// Holds the switch state memory, the fragment bitmap memory and the control.
// Depends on sfct_pkg.
//
// Usage: a fragment beat (switch index, sketch id, fragment id) is taken at a
// rising edge where start is high and busy is low. Exactly one result beat
// follows for every fragment: it sits on the o_ result ports for one cycle,
// marked by o_strobe and registered from the processing state. The receiver
// cannot stall, so the result must be taken in that cycle.
// Both memories are read at the accepting edge. The following cycle merges the
// switch record and bitmap word, computes the result, and writes both back, so
// an ordinary fragment holds the block only for its processing state, and a
// new beat can be taken in the cycle its result is shown. No new beat is
// taken while one is being processed.
// When the sketch id of a switch changes, that switch's bitmap rows are
// cleared one row per cycle, and busy stays high for the whole sweep. The
// result of the restarting fragment is still shown in the usual cycle.
// After reset a clearing pass walks every bitmap row and rewrites every switch
// record, with busy high throughout.
// The progress step register may be written at any edge through i_cfg_we; it
// resets to 1 and is meant to change only while the block is idle.
// A fragment with a switch index beyond the table changes nothing and yields
// a result beat of all zeros.
module sketch_fragment_coverage_tracker #(
    parameter int unsigned SWITCH_SLOTS   = sfct_pkg::SWITCH_SLOTS_DEF,
    parameter int unsigned FRAGMENT_SLOTS = sfct_pkg::FRAGMENT_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfct_pkg::LEVEL_W-1:0]  i_cfg_wdata,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_switch_index,
    input  logic [15:0]                   i_sketch_id,
    input  logic [15:0]                   i_fragment_id,
    output logic                          o_strobe,
    output logic [sfct_pkg::TOTAL_W-1:0]  o_total_fragments,
    output logic [sfct_pkg::DIST_W-1:0]   o_distinct_fragments,
    output logic                          o_is_new_fragment,
    output logic                          o_sketch_restarted,
    output logic                          o_progress_event,
    output logic [sfct_pkg::LEVEL_W-1:0]  o_progress_percent
);
    import sfct_pkg::*;

    localparam int unsigned SW_W     = (SWITCH_SLOTS > 1) ? $clog2(SWITCH_SLOTS) : 1;
    localparam int unsigned ROWS     = (FRAGMENT_SLOTS + WORD_W - 1) / WORD_W;
    localparam int unsigned ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned AW       = SW_W + ROW_W;
    localparam int unsigned BM_DEPTH = SWITCH_SLOTS * (2 ** ROW_W);

    localparam logic [AW-1:0]    CNT_LAST = AW'(BM_DEPTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = '1;

    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_PROC  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    // Storage.
    logic [WORD_W-1:0] bm_mem [0:BM_DEPTH-1];
    t_sw_rec           st_mem [0:SWITCH_SLOTS-1];

    // Control and captured beat.
    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_cnt, n_cnt;
    logic [LEVEL_W-1:0]  r_step;
    logic [SW_W-1:0]     r_sw;
    logic                r_sw_ok;
    logic [SKETCH_W-1:0] r_sketch;
    logic [ROW_W-1:0]    r_row;
    logic [BIT_W-1:0]    r_bit;
    logic                r_frag_ok;
    logic [WORD_W-1:0]   r_clr_word;
    logic [WORD_W-1:0]   r_bm_rdata;
    t_sw_rec             r_st_rdata;

    // Output registers.
    logic                r_strobe;
    logic [TOTAL_W-1:0]  r_total;
    logic [DIST_W-1:0]   r_distinct;
    logic                r_is_new;
    logic                r_restarted;
    logic                r_event;
    logic [LEVEL_W-1:0]  r_percent;

    // Input address decode.
    logic                accept;
    logic [31:0]         sw_ext;
    logic [31:0]         row_ext;
    logic [SW_W-1:0]     sw_addr;
    logic [ROW_W-1:0]    row_addr;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign sw_ext  = 32'(i_switch_index);
    assign row_ext = 32'(i_fragment_id[15:BIT_W]);
    assign sw_addr = sw_ext[SW_W-1:0];
    assign row_addr = row_ext[ROW_W-1:0];

    // Merge of the fetched record and word with the captured beat.
    logic                restart;
    logic [DIST_W-1:0]   base_dist;
    logic [LEVEL_W-1:0]  base_lvl;
    logic [WORD_W-1:0]   base_word;
    logic [WORD_W-1:0]   bit_mask;
    logic                is_new;
    logic [DIST_W-1:0]   n_distinct;
    logic [TOTAL_W-1:0]  n_total;
    logic [PROD_W-1:0]   prod_dist;
    logic [PROD_W-1:0]   prod_lvl;
    logic                hit;
    logic [LEVEL_W:0]    lvl_sum;
    logic [LEVEL_W-1:0]  n_level;
    t_sw_rec             n_rec;

    always_comb begin
        restart    = (r_sketch != r_st_rdata.sketch);
        base_dist  = restart ? '0 : r_st_rdata.distinct;
        base_lvl   = restart ? '0 : r_st_rdata.level;
        base_word  = restart ? '0 : r_bm_rdata;
        bit_mask   = WORD_W'(1) << r_bit;
        is_new     = r_frag_ok && ((base_word & bit_mask) == '0);
        n_distinct = base_dist + DIST_W'(is_new);
        n_total    = (r_st_rdata.total == '1) ? r_st_rdata.total
                                              : r_st_rdata.total + TOTAL_W'(1);
        // Integer form of distinct / FRAGMENT_SLOTS >= level percent.
        prod_dist  = PROD_W'(n_distinct) * PCT_SCALE;
        prod_lvl   = PROD_W'(base_lvl) * PROD_W'(FRAGMENT_SLOTS);
        hit        = (prod_dist >= prod_lvl);
        lvl_sum    = (LEVEL_W + 1)'(base_lvl) + (LEVEL_W + 1)'(r_step);
        if (!hit) begin
            n_level = base_lvl;
        end else if (lvl_sum > (LEVEL_W + 1)'(LEVEL_MAX)) begin
            n_level = LEVEL_MAX;
        end else begin
            n_level = lvl_sum[LEVEL_W-1:0];
        end
        n_rec.sketch   = r_sketch;
        n_rec.total    = n_total;
        n_rec.distinct = n_distinct;
        n_rec.level    = n_level;
    end

    // Memory write ports.
    logic              bm_we;
    logic [AW-1:0]     bm_waddr;
    logic [WORD_W-1:0] bm_wdata;
    logic              st_we;
    logic [SW_W-1:0]   st_waddr;
    t_sw_rec           st_wdata;

    always_comb begin
        bm_we    = 1'b0;
        bm_waddr = {r_sw, r_row};
        bm_wdata = base_word | bit_mask;
        st_we    = 1'b0;
        st_waddr = r_sw;
        st_wdata = n_rec;
        n_state  = r_state;
        n_cnt    = r_cnt;
        case (r_state)
            ST_INIT: begin
                bm_we             = 1'b1;
                bm_waddr          = r_cnt;
                bm_wdata          = '0;
                st_we             = 1'b1;
                st_waddr          = r_cnt[AW-1:ROW_W];
                st_wdata.sketch   = SKETCH_RESET;
                st_wdata.total    = '0;
                st_wdata.distinct = '0;
                st_wdata.level    = '0;
                n_cnt             = r_cnt + AW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_PROC;
                end
            end
            ST_PROC: begin
                n_state = ST_IDLE;
                if (r_sw_ok) begin
                    st_we = 1'b1;
                    if (restart) begin
                        // The bitmap row sweep also places the new bit.
                        n_state = ST_CLEAR;
                        n_cnt   = '0;
                    end else begin
                        bm_we = is_new;
                    end
                end
            end
            ST_CLEAR: begin
                bm_we    = 1'b1;
                bm_waddr = {r_sw, r_cnt[ROW_W-1:0]};
                bm_wdata = (r_cnt[ROW_W-1:0] == r_row) ? r_clr_word : '0;
                n_cnt    = r_cnt + AW'(1);
                if (r_cnt[ROW_W-1:0] == ROW_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    // Bitmap memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (accept) begin
            r_bm_rdata <= bm_mem[{sw_addr, row_addr}];
        end
    end

    // Switch state memory.
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        if (accept) begin
            r_st_rdata <= st_mem[sw_addr];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_cnt    <= '0;
            r_step   <= STEP_RESET;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_strobe <= (r_state == ST_PROC);
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
        end
    end

    // Captured beat and result payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sw      <= sw_addr;
            r_sw_ok   <= (sw_ext < SWITCH_SLOTS);
            r_sketch  <= i_sketch_id;
            r_row     <= row_addr;
            r_bit     <= i_fragment_id[BIT_W-1:0];
            r_frag_ok <= (32'(i_fragment_id) < FRAGMENT_SLOTS);
        end
        if (r_state == ST_PROC) begin
            r_clr_word  <= is_new ? bit_mask : '0;
            r_total     <= r_sw_ok ? n_total : '0;
            r_distinct  <= r_sw_ok ? n_distinct : '0;
            r_is_new    <= r_sw_ok && is_new;
            r_restarted <= r_sw_ok && restart;
            r_event     <= r_sw_ok && hit;
            r_percent   <= (r_sw_ok && hit) ? base_lvl : '0;
        end
    end

    assign o_strobe             = r_strobe;
    assign o_total_fragments    = r_total;
    assign o_distinct_fragments = r_distinct;
    assign o_is_new_fragment    = r_is_new;
    assign o_sketch_restarted   = r_restarted;
    assign o_progress_event     = r_event;
    assign o_progress_percent   = r_percent;

`ifndef NO_ASSERTIONS
    // A result beat follows exactly one processing cycle.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state) == ST_PROC)
        else $error("result beat without a processing cycle");

    // A restart always enters the row clearing sweep with the counter at zero.
    a_restart_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_sketch_restarted |-> r_state == ST_CLEAR && r_cnt == '0)
        else $error("restart did not start a bitmap clear");

    // A new fragment always leaves a nonzero distinct count.
    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_new_fragment |-> o_distinct_fragments != '0)
        else $error("new fragment with zero distinct count");

    // A reported level is only nonzero with an event, and never beyond 100.
    a_percent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_progress_event || o_progress_percent == '0)
                     && o_progress_percent <= 7'd100)
        else $error("progress percent out of place");

    // No beat is taken while a clearing sweep is running.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR || r_state == ST_INIT) |-> !accept)
        else $error("beat accepted during a clearing sweep");
`endif

endmodule
